// ----- sv/baro_sensor_compensation_defines.svh -----
// assertion macros for the barometric compensation block
`ifndef BARO_SENSOR_COMPENSATION_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on the rising edge of clk outside reset
`define BSC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pipeline check failed");

// next-cycle implication, checked on the rising edge of clk outside reset
`define BSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pipeline check failed");

`else

`define BSC_ASSERT_NOW(lbl, ante, cons)
`define BSC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- sv/bsc_pkg.sv -----
// shared constants, widths and types of the barometric compensation pipeline
`default_nettype none

package bsc_pkg;

	// pipeline depth
	localparam int NUM_STAGES = 9;

	// port widths
	localparam int RAW_W      = 24;
	localparam int CAL_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int TOUT_W     = 19;
	localparam int P_W        = 32;

	// internal widths
	localparam int DT_W       = 25;
	localparam int TPROD_W    = 42;
	localparam int DTSQ_W     = 50;
	localparam int LO_W       = 19;
	localparam int T2_W       = 17;
	localparam int TEMP_W     = 20;
	localparam int LIN_W      = 42;
	localparam int SQ_W       = 36;
	localparam int CORR_W     = 40;
	localparam int OS_W       = 42;
	localparam int SENS_LO_W  = 21;
	localparam int SENS_HI_W  = OS_W - SENS_LO_W;
	localparam int PP_LO_W    = RAW_W + SENS_LO_W;
	localparam int PP_HI_W    = RAW_W + 1 + SENS_HI_W;
	localparam int Q_W        = PP_HI_W + 1;

	// shift amounts
	localparam int TEMP_SHIFT      = 23;
	localparam int T2_SHIFT        = 31;
	localparam int OFF_SHIFT       = 7;
	localparam int SENS_SHIFT      = 8;
	localparam int OFF_BASE_SHIFT  = 16;
	localparam int SENS_BASE_SHIFT = 15;
	localparam int REF_SHIFT       = 8;
	localparam int P2_SHIFT        = 15;

	// temperature thresholds in 0.01 degC
	localparam int TEMP_REF    = 2000;
	localparam int TEMP_VLOW   = -1500;
	localparam int TEMP_HIGH   = 4500;
	// same thresholds measured from TEMP_REF
	localparam int VLOW_DELTA  = TEMP_REF - TEMP_VLOW;
	localparam int HIGH_DELTA  = TEMP_HIGH - TEMP_REF;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_C1    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_C2    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_C3    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_C4    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_C5    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_C6    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MODEL = 3'd6;

	// second-order correction selects
	typedef struct packed {
		logic low;
		logic very_low;
		logic high;
		logic model;
	} corr_flags_t;

endpackage

`default_nettype wire

// ----- sv/bsc_correction.sv -----
// second-order offset and sensitivity corrections from the temperature squares
`default_nettype none

module bsc_correction (
	input  wire logic [bsc_pkg::SQ_W-1:0]          lo_sq,
	input  wire logic [bsc_pkg::SQ_W-1:0]          vlo_sq,
	input  wire logic [bsc_pkg::SQ_W-1:0]          hi_sq,
	input  wire bsc_pkg::corr_flags_t              flags,
	output logic signed [bsc_pkg::CORR_W-1:0]      off2,
	output logic signed [bsc_pkg::CORR_W-1:0]      sens2
);

	localparam int EXT_W = bsc_pkg::CORR_W - bsc_pkg::SQ_W;

	logic [bsc_pkg::CORR_W-1:0] lo_w;
	logic [bsc_pkg::CORR_W-1:0] vlo_w;
	logic [bsc_pkg::CORR_W-1:0] hi_w;
	logic [bsc_pkg::CORR_W-1:0] m0_off;
	logic [bsc_pkg::CORR_W-1:0] m0_sens;
	logic [bsc_pkg::CORR_W-1:0] m1_off;
	logic [bsc_pkg::CORR_W-1:0] m1_sens;
	logic [bsc_pkg::CORR_W-1:0] m0_vlo_sens;
	logic [bsc_pkg::CORR_W-1:0] m1_vlo_off;
	logic [bsc_pkg::CORR_W-1:0] m1_vlo_sens;

	assign lo_w  = {{EXT_W{1'b0}}, lo_sq};
	assign vlo_w = {{EXT_W{1'b0}}, vlo_sq};
	assign hi_w  = {{EXT_W{1'b0}}, hi_sq};

	// very low temperature terms, shift-add
	assign m0_vlo_sens = flags.very_low ? (vlo_w << 1) : '0;
	assign m1_vlo_off  = flags.very_low ? ((vlo_w << 3) - vlo_w) : '0;
	assign m1_vlo_sens = flags.very_low ?
		(((vlo_w << 3) + (vlo_w << 1) + vlo_w) >> 1) : '0;

	// first model table
	assign m0_off  = (lo_w << 1) + lo_w;
	assign m0_sens = ((lo_w >> 3) << 3) - (lo_w >> 3) + m0_vlo_sens;

	// second model table
	assign m1_off  = (((lo_w << 2) + lo_w) >> 1) + m1_vlo_off;
	assign m1_sens = ((lo_w >> 2) << 2) + (lo_w >> 2) + m1_vlo_sens;

	// pick the rule that applies
	always_comb begin
		off2  = '0;
		sens2 = '0;
		if (flags.low) begin
			if (flags.model) begin
				off2  = $signed(m1_off);
				sens2 = $signed(m1_sens);
			end else begin
				off2  = $signed(m0_off);
				sens2 = $signed(m0_sens);
			end
		end else if (flags.high) begin
			sens2 = -$signed(hi_w >> 3);
		end
	end

endmodule

`default_nettype wire

// ----- sv/baro_sensor_compensation.sv -----
// Barometric sensor compensation: nine-stage pipeline. Throughput is one item
// per clock while the output is not stalled; a stalled output only backs up
// the stages behind it, and empty stages keep taking items.
// The depth is set by the multiply chain dT -> TEMP -> square -> SENS -> P.
// Reset clears all stage valid bits and the calibration registers to zero.
`default_nettype none
`include "baro_sensor_compensation_defines.svh"

module baro_sensor_compensation (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration
	input  wire logic                                wr_en,
	input  wire logic [bsc_pkg::CFG_IDX_W-1:0]       wr_index,
	input  wire logic [bsc_pkg::CAL_W-1:0]           wr_data,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [bsc_pkg::RAW_W-1:0]           raw_pressure,
	input  wire logic [bsc_pkg::RAW_W-1:0]           raw_temperature,
	// output channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [bsc_pkg::TOUT_W-1:0]        temperature_centi,
	output logic signed [bsc_pkg::P_W-1:0]           pressure_centi
);

	localparam int NS = bsc_pkg::NUM_STAGES;

	// calibration registers
	logic [bsc_pkg::CAL_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
	logic                      model_q;

	// stage control
	logic [NS:1] stage_valid_q;
	logic [NS:1] advance;

	// stage 1
	logic signed [bsc_pkg::DT_W-1:0]   dt_c, dt_s1;
	logic [bsc_pkg::RAW_W-1:0]         d1_s1;
	// stage 2
	logic signed [bsc_pkg::TPROD_W-1:0] tprod_c, tprod_s2;
	logic signed [bsc_pkg::DTSQ_W-1:0]  dtsq_c;
	logic [bsc_pkg::T2_W-1:0]           t2_s2;
	logic signed [bsc_pkg::LIN_W-1:0]   olin_c, olin_s2, slin_c, slin_s2;
	logic [bsc_pkg::RAW_W-1:0]          d1_s2;
	// stage 3
	logic signed [bsc_pkg::LO_W-1:0]    lo_c, lo_s3;
	logic signed [bsc_pkg::OS_W-1:0]    off1_c, off1_s3, sens1_c, sens1_s3;
	logic [bsc_pkg::T2_W-1:0]           t2_s3;
	bsc_pkg::corr_flags_t               flags_c, flags_s3;
	logic [bsc_pkg::RAW_W-1:0]          d1_s3;
	// stage 4
	logic signed [bsc_pkg::TEMP_W-1:0]  lo_ext, temp_c, t_c, vlo_c, hi_c;
	logic signed [2*bsc_pkg::TEMP_W-1:0] lo_sq_c, vlo_sq_c, hi_sq_c;
	logic [bsc_pkg::SQ_W-1:0]           lo_sq_s4, vlo_sq_s4, hi_sq_s4;
	logic [bsc_pkg::TOUT_W-1:0]         t_s4;
	bsc_pkg::corr_flags_t               flags_s4;
	logic signed [bsc_pkg::OS_W-1:0]    off1_s4, sens1_s4;
	logic [bsc_pkg::RAW_W-1:0]          d1_s4;
	// stage 5
	logic signed [bsc_pkg::CORR_W-1:0]  off2_c, sens2_c, off2_s5, sens2_s5;
	logic signed [bsc_pkg::OS_W-1:0]    off1_s5, sens1_s5;
	logic [bsc_pkg::TOUT_W-1:0]         t_s5;
	logic [bsc_pkg::RAW_W-1:0]          d1_s5;
	// stage 6
	logic signed [bsc_pkg::OS_W-1:0]    off_s6, sens_s6;
	logic [bsc_pkg::TOUT_W-1:0]         t_s6;
	logic [bsc_pkg::RAW_W-1:0]          d1_s6;
	// stage 7
	logic [bsc_pkg::PP_LO_W-1:0]        pp_lo_c, pp_lo_s7;
	logic signed [bsc_pkg::PP_HI_W-1:0] pp_hi_c, pp_hi_s7;
	logic signed [bsc_pkg::OS_W-1:0]    off_s7;
	logic [bsc_pkg::TOUT_W-1:0]         t_s7;
	// stage 8
	logic signed [bsc_pkg::PP_HI_W-1:0] sum_c, sum_s8;
	logic signed [bsc_pkg::OS_W-1:0]    off_s8;
	logic [bsc_pkg::TOUT_W-1:0]         t_s8;
	// stage 9
	logic signed [bsc_pkg::Q_W-1:0]     q_c;
	logic [bsc_pkg::P_W-1:0]            p_s9;
	logic [bsc_pkg::TOUT_W-1:0]         t_s9;

	// calibration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q    <= '0;
			c2_q    <= '0;
			c3_q    <= '0;
			c4_q    <= '0;
			c5_q    <= '0;
			c6_q    <= '0;
			model_q <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				bsc_pkg::REG_C1:    c1_q    <= wr_data;
				bsc_pkg::REG_C2:    c2_q    <= wr_data;
				bsc_pkg::REG_C3:    c3_q    <= wr_data;
				bsc_pkg::REG_C4:    c4_q    <= wr_data;
				bsc_pkg::REG_C5:    c5_q    <= wr_data;
				bsc_pkg::REG_C6:    c6_q    <= wr_data;
				bsc_pkg::REG_MODEL: model_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// a stage moves when it is empty or the stage after it moves
	always_comb begin
		advance[NS] = !stage_valid_q[NS] || !out_stall;
		for (int k = NS - 1; k >= 1; k--) begin
			advance[k] = !stage_valid_q[k] || advance[k+1];
		end
	end

	assign in_stall  = !advance[1];
	assign out_valid = stage_valid_q[NS];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (advance[1]) begin
				stage_valid_q[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (advance[k]) begin
					stage_valid_q[k] <= stage_valid_q[k-1];
				end
			end
		end
	end

	// stage 1: temperature difference
	assign dt_c = $signed({1'b0, raw_temperature})
		- $signed({1'b0, c5_q, {bsc_pkg::REF_SHIFT{1'b0}}});

	always_ff @(posedge clk) begin
		if (advance[1]) begin
			dt_s1 <= dt_c;
			d1_s1 <= raw_pressure;
		end
	end

	// stage 2: products of dT
	assign tprod_c = dt_s1 * $signed({1'b0, c6_q});
	assign dtsq_c  = dt_s1 * dt_s1;
	assign olin_c  = dt_s1 * $signed({1'b0, c4_q});
	assign slin_c  = dt_s1 * $signed({1'b0, c3_q});

	always_ff @(posedge clk) begin
		if (advance[2]) begin
			tprod_s2 <= tprod_c;
			t2_s2    <= dtsq_c[bsc_pkg::T2_SHIFT+bsc_pkg::T2_W-1:bsc_pkg::T2_SHIFT];
			olin_s2  <= olin_c;
			slin_s2  <= slin_c;
			d1_s2    <= d1_s1;
		end
	end

	// stage 3: first-order temperature, offset and sensitivity
	assign lo_c    = tprod_s2[bsc_pkg::TEMP_SHIFT+bsc_pkg::LO_W-1:bsc_pkg::TEMP_SHIFT];
	assign off1_c  = $signed({{(bsc_pkg::OS_W-bsc_pkg::CAL_W-bsc_pkg::OFF_BASE_SHIFT){1'b0}},
		c2_q, {bsc_pkg::OFF_BASE_SHIFT{1'b0}}}) + (olin_s2 >>> bsc_pkg::OFF_SHIFT);
	assign sens1_c = $signed({{(bsc_pkg::OS_W-bsc_pkg::CAL_W-bsc_pkg::SENS_BASE_SHIFT){1'b0}},
		c1_q, {bsc_pkg::SENS_BASE_SHIFT{1'b0}}}) + (slin_s2 >>> bsc_pkg::SENS_SHIFT);

	// correction selects, thresholds taken relative to 20.00 degC
	assign flags_c.low      = lo_c[bsc_pkg::LO_W-1];
	assign flags_c.very_low = lo_c < -bsc_pkg::VLOW_DELTA;
	assign flags_c.high     = !model_q && (lo_c > bsc_pkg::HIGH_DELTA);
	assign flags_c.model    = model_q;

	always_ff @(posedge clk) begin
		if (advance[3]) begin
			lo_s3    <= lo_c;
			t2_s3    <= t2_s2;
			off1_s3  <= off1_c;
			sens1_s3 <= sens1_c;
			flags_s3 <= flags_c;
			d1_s3    <= d1_s2;
		end
	end

	// stage 4: squares and final temperature
	assign lo_ext = {lo_s3[bsc_pkg::LO_W-1], lo_s3};
	assign temp_c = lo_ext + bsc_pkg::TEMP_W'(bsc_pkg::TEMP_REF);
	assign t_c    = temp_c - (flags_s3.low ?
		$signed({{(bsc_pkg::TEMP_W-bsc_pkg::T2_W){1'b0}}, t2_s3}) : '0);
	assign vlo_c  = lo_ext + bsc_pkg::TEMP_W'(bsc_pkg::VLOW_DELTA);
	assign hi_c   = lo_ext - bsc_pkg::TEMP_W'(bsc_pkg::HIGH_DELTA);

	assign lo_sq_c  = lo_ext * lo_ext;
	assign vlo_sq_c = vlo_c * vlo_c;
	assign hi_sq_c  = hi_c * hi_c;

	always_ff @(posedge clk) begin
		if (advance[4]) begin
			lo_sq_s4  <= lo_sq_c[bsc_pkg::SQ_W-1:0];
			vlo_sq_s4 <= vlo_sq_c[bsc_pkg::SQ_W-1:0];
			hi_sq_s4  <= hi_sq_c[bsc_pkg::SQ_W-1:0];
			t_s4      <= t_c[bsc_pkg::TOUT_W-1:0];
			flags_s4  <= flags_s3;
			off1_s4   <= off1_s3;
			sens1_s4  <= sens1_s3;
			d1_s4     <= d1_s3;
		end
	end

	// stage 5: second-order terms
	bsc_correction u_correction (
		.lo_sq  (lo_sq_s4),
		.vlo_sq (vlo_sq_s4),
		.hi_sq  (hi_sq_s4),
		.flags  (flags_s4),
		.off2   (off2_c),
		.sens2  (sens2_c)
	);

	always_ff @(posedge clk) begin
		if (advance[5]) begin
			off2_s5  <= off2_c;
			sens2_s5 <= sens2_c;
			off1_s5  <= off1_s4;
			sens1_s5 <= sens1_s4;
			t_s5     <= t_s4;
			d1_s5    <= d1_s4;
		end
	end

	// stage 6: corrected offset and sensitivity
	always_ff @(posedge clk) begin
		if (advance[6]) begin
			off_s6  <= off1_s5 - bsc_pkg::OS_W'(off2_s5);
			sens_s6 <= sens1_s5 - bsc_pkg::OS_W'(sens2_s5);
			t_s6    <= t_s5;
			d1_s6   <= d1_s5;
		end
	end

	// stage 7: D1 * SENS as two partial products
	assign pp_lo_c = d1_s6 * sens_s6[bsc_pkg::SENS_LO_W-1:0];
	assign pp_hi_c = $signed({1'b0, d1_s6}) * $signed(sens_s6[bsc_pkg::OS_W-1:bsc_pkg::SENS_LO_W]);

	always_ff @(posedge clk) begin
		if (advance[7]) begin
			pp_lo_s7 <= pp_lo_c;
			pp_hi_s7 <= pp_hi_c;
			off_s7   <= off_s6;
			t_s7     <= t_s6;
		end
	end

	// stage 8: (D1 * SENS) >> 21, the high partial product already sits at that weight
	assign sum_c = pp_hi_s7 + $signed({{(bsc_pkg::PP_HI_W-bsc_pkg::RAW_W){1'b0}},
		pp_lo_s7[bsc_pkg::PP_LO_W-1:bsc_pkg::SENS_LO_W]});

	always_ff @(posedge clk) begin
		if (advance[8]) begin
			sum_s8 <= sum_c;
			off_s8 <= off_s7;
			t_s8   <= t_s7;
		end
	end

	// stage 9: subtract offset, shift down and keep the low word
	assign q_c = {sum_s8[bsc_pkg::PP_HI_W-1], sum_s8}
		- {{(bsc_pkg::Q_W-bsc_pkg::OS_W){off_s8[bsc_pkg::OS_W-1]}}, off_s8};

	always_ff @(posedge clk) begin
		if (advance[9]) begin
			p_s9 <= q_c[bsc_pkg::P2_SHIFT+bsc_pkg::P_W-1:bsc_pkg::P2_SHIFT];
			t_s9 <= t_s8;
		end
	end

	assign temperature_centi = $signed(t_s9);
	assign pressure_centi    = $signed(p_s9);

	// checks
	`BSC_ASSERT_NOW(a_stall_only_when_full, in_stall, &stage_valid_q)
	`BSC_ASSERT_NEXT(a_hold_behind_stall, stage_valid_q[NS-1] && stage_valid_q[NS] && out_stall, stage_valid_q[NS-1])
	`BSC_ASSERT_NOW(a_no_corr_in_band, stage_valid_q[4] && !flags_s4.low && !flags_s4.high, off2_c == '0 && sens2_c == '0)
	`BSC_ASSERT_NOW(a_high_excludes_low, stage_valid_q[4] && flags_s4.high, !flags_s4.low && !flags_s4.model)

endmodule

`default_nettype wire
